FILE: src/lpmt_pkg.sv
package lpmt_pkg;

  // field widths fixed by the stream format
  localparam int unsigned ADDR_FIELD_W = 32;
  localparam int unsigned BC_W         = 6;
  localparam int unsigned RTR_W        = 16;
  localparam int unsigned ML_W         = 6;
  localparam int unsigned ST_W         = 2;
  localparam int unsigned S_TDATA_W    = 56;
  localparam int unsigned M_TDATA_W    = 24;

  // request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // result status
  localparam logic [ST_W-1:0] ST_HIT  = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_DONE = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL = 2'd3;

  // control that travels with a word down the chain
  typedef struct packed {
    logic vld;
    logic lookup;
    logic hit;     // lookup: a match was found; insert: the route has been stored
  } lpmt_ctl_t;

endpackage

FILE: src/lpmt_cell.sv
module lpmt_cell #(
  parameter int unsigned ADDR_BITS = 32,
  parameter int unsigned LEN_W     = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  lpmt_pkg::lpmt_ctl_t           in_ctl,
  input  logic [ADDR_BITS-1:0]          in_key,
  input  logic [ADDR_BITS-1:0]          in_mask,
  input  logic [LEN_W-1:0]              in_len,
  input  logic [lpmt_pkg::RTR_W-1:0]    in_rtr,
  input  logic [LEN_W-1:0]              in_best,
  output lpmt_pkg::lpmt_ctl_t           out_ctl,
  output logic [ADDR_BITS-1:0]          out_key,
  output logic [ADDR_BITS-1:0]          out_mask,
  output logic [LEN_W-1:0]              out_len,
  output logic [lpmt_pkg::RTR_W-1:0]    out_rtr,
  output logic [LEN_W-1:0]              out_best,
  output logic                          occupied
);
  import lpmt_pkg::*;

  logic                 ent_valid;
  logic [ADDR_BITS-1:0] ent_prefix;
  logic [ADDR_BITS-1:0] ent_mask;
  logic [LEN_W-1:0]     ent_len;
  logic [RTR_W-1:0]     ent_router;

  logic                 match_ins;
  logic                 match_lkp;
  logic                 wr_new;
  logic                 wr_rtr;
  lpmt_ctl_t            ctl_next;
  logic [RTR_W-1:0]     rtr_next;
  logic [LEN_W-1:0]     best_next;

  assign match_ins = ent_valid && (ent_len == in_len) && (ent_prefix == in_key);
  // key is already cut to the word's own length, so cutting again to ours is enough
  assign match_lkp = ent_valid && (ent_len <= in_len) &&
                     ((in_key & ent_mask) == ent_prefix) &&
                     (!in_ctl.hit || (ent_len > in_best));

  always_comb begin
    ctl_next  = in_ctl;
    rtr_next  = in_rtr;
    best_next = in_best;
    wr_new    = 1'b0;
    wr_rtr    = 1'b0;
    if (in_ctl.vld) begin
      if (in_ctl.lookup) begin
        if (match_lkp) begin
          ctl_next.hit = 1'b1;
          rtr_next     = ent_router;
          best_next    = ent_len;
        end
      end else if (!in_ctl.hit) begin
        // entries fill from cell 0 up, so the first free cell ends the search
        if (match_ins) begin
          wr_rtr       = 1'b1;
          ctl_next.hit = 1'b1;
        end else if (!ent_valid) begin
          wr_new       = 1'b1;
          ctl_next.hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      out_ctl   <= '0;
    end else if (adv) begin
      out_ctl <= ctl_next;
      if (wr_new) begin
        ent_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_key  <= in_key;
      out_mask <= in_mask;
      out_len  <= in_len;
      out_rtr  <= rtr_next;
      out_best <= best_next;
      if (wr_new) begin
        ent_prefix <= in_key;
        ent_mask   <= in_mask;
        ent_len    <= in_len;
        ent_router <= in_rtr;
      end else if (wr_rtr) begin
        ent_router <= in_rtr;
      end
    end
  end

  assign occupied = ent_valid;

endmodule

FILE: src/longest_prefix_match_table_core.sv
// Longest-prefix-match route table built as a chain of TABLE_ENTRIES cells, one route per
// cell. Every word (insert or lookup) walks the chain one cell per cycle, so a new word can
// enter every cycle and results leave in order from a register behind the last cell;
// a stall on the output side freezes the whole chain. An insert updates the router of a
// matching stored prefix or claims the first free cell; with no free cell it returns table
// full. A lookup returns the longest stored prefix matching the address, or a miss. The
// table is empty after reset and needs no clearing pass.
module longest_prefix_match_table_core #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned ADDR_BITS     = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // addr_bits[31:0], bit_count[37:32], router_in[53:38], zero pad
  input  logic [lpmt_pkg::S_TDATA_W-1:0]    s_tdata,
  // req_type[0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // router_out[15:0], match_length[21:16], zero pad
  output logic [lpmt_pkg::M_TDATA_W-1:0]    m_tdata,
  // status[1:0]
  output logic [lpmt_pkg::ST_W-1:0]         m_tuser
);
  import lpmt_pkg::*;

  localparam int unsigned LEN_W = $clog2(ADDR_BITS + 1);
  localparam int unsigned CMP_W = (LEN_W > BC_W) ? LEN_W : BC_W;

  logic                      adv;
  logic [BC_W-1:0]           bc;
  logic [CMP_W-1:0]          len_wide;
  logic [LEN_W-1:0]          len_in;
  logic [ADDR_BITS-1:0]      mask_in;

  lpmt_ctl_t                 c_ctl  [TABLE_ENTRIES+1];
  logic [ADDR_BITS-1:0]      c_key  [TABLE_ENTRIES+1];
  logic [ADDR_BITS-1:0]      c_mask [TABLE_ENTRIES+1];
  logic [LEN_W-1:0]          c_len  [TABLE_ENTRIES+1];
  logic [RTR_W-1:0]          c_rtr  [TABLE_ENTRIES+1];
  logic [LEN_W-1:0]          c_best [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0]  occ;

  lpmt_ctl_t                 last_ctl;
  logic [ST_W-1:0]           st_next;
  logic [RTR_W-1:0]          rtr_out_next;
  logic [ML_W-1:0]           ml_next;
  logic [RTR_W-1:0]          router_out;
  logic [ML_W-1:0]           match_length;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // clamp length, build the leading-bits mask once at the entry
  assign bc       = s_tdata[ADDR_FIELD_W +: BC_W];
  assign len_wide = (CMP_W'(bc) > CMP_W'(ADDR_BITS)) ? CMP_W'(ADDR_BITS) : CMP_W'(bc);
  assign len_in   = LEN_W'(len_wide);
  assign mask_in  = ~({ADDR_BITS{1'b1}} >> len_in);

  always_comb begin
    c_ctl[0].vld    = s_tvalid;
    c_ctl[0].lookup = (s_tuser == REQ_LOOKUP);
    c_ctl[0].hit    = 1'b0;
  end
  assign c_key[0]  = ADDR_BITS'(s_tdata[ADDR_FIELD_W-1:0]) & mask_in;
  assign c_mask[0] = mask_in;
  assign c_len[0]  = len_in;
  assign c_rtr[0]  = s_tdata[ADDR_FIELD_W+BC_W +: RTR_W];
  assign c_best[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lpmt_cell #(
      .ADDR_BITS (ADDR_BITS),
      .LEN_W     (LEN_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_ctl   (c_ctl[i]),
      .in_key   (c_key[i]),
      .in_mask  (c_mask[i]),
      .in_len   (c_len[i]),
      .in_rtr   (c_rtr[i]),
      .in_best  (c_best[i]),
      .out_ctl  (c_ctl[i+1]),
      .out_key  (c_key[i+1]),
      .out_mask (c_mask[i+1]),
      .out_len  (c_len[i+1]),
      .out_rtr  (c_rtr[i+1]),
      .out_best (c_best[i+1]),
      .occupied (occ[i])
    );
  end

  assign last_ctl = c_ctl[TABLE_ENTRIES];

  always_comb begin
    st_next      = ST_DONE;
    rtr_out_next = '0;
    ml_next      = '0;
    if (last_ctl.lookup) begin
      if (last_ctl.hit) begin
        st_next      = ST_HIT;
        rtr_out_next = c_rtr[TABLE_ENTRIES];
        ml_next      = ML_W'(c_best[TABLE_ENTRIES]);
      end else begin
        st_next = ST_MISS;
      end
    end else if (!last_ctl.hit) begin
      st_next = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= last_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser      <= st_next;
      router_out   <= rtr_out_next;
      match_length <= ml_next;
    end
  end

  assign m_tdata = {(M_TDATA_W - RTR_W - ML_W)'(0), match_length, router_out};

  // occupied cells always form an unbroken run from cell 0
  a_occ_contig: assert property (@(posedge clk) disable iff (rst)
    (occ & (occ + 1'b1)) == '0)
    else $error("route table has a hole");

  // only a hit carries a router and a length
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_HIT) |-> (m_tdata == '0))
    else $error("non-hit result with nonzero payload");

  // a full table can only be reported while every cell is occupied
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL) |-> (occ == '1))
    else $error("table full reported with a free cell");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented right after reset");

endmodule
